// ----- sv/acb_pkg.sv -----
// ----------------------------------------------------------------------------
// acb_pkg: shared types and constants for the arc to cubic bezier block
// fixed point constants, path command kinds, controller/datapath interface
// ----------------------------------------------------------------------------
`default_nettype none

package acb_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 24;

	// angles are Q5.26, cordic works in Q2.30
	localparam logic [28:0] QUARTER_TURN = 29'd105414357;
	localparam logic [28:0] FULL_TURN    = 29'd421657428;
	localparam logic [28:0] HALF_QUARTER = 29'd52707178;
	// whole number of full turns, keeps the reduction input positive
	localparam logic [32:0] REDUCE_BIAS  = 33'd3373259424;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		KIND_MOVE  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_CUBIC = 2'd2
	} seg_kind_t;

	typedef enum logic [1:0] {
		SRC_START = 2'd0,
		SRC_END   = 2'd1,
		SRC_TAN   = 2'd2
	} cordic_src_t;

	typedef struct packed {
		logic        load;
		logic        mod_step;
		logic        sweep_set;
		logic        cordic_start;
		cordic_src_t cordic_src;
		logic        cap_s;
		logic        cap_e;
		logic        mul_num;
		logic        div_start;
		logic        pt_step;
		logic [2:0]  pt_idx;
		logic [1:0]  pt_phase;
		logic        emit_move;
		logic        emit_cubic;
	} acb_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic sweep_zero;
		logic last_seg;
		logic cordic_done;
		logic div_done;
	} acb_stat_t;

	// arctangent of 2^-i in Q2.30
	function automatic logic signed [33:0] atan_step(input logic [5:0] i);
		logic signed [33:0] r;
		r = '0;
		case (i)
			6'd0: r = 34'sd843314857;
			6'd1: r = 34'sd497837829;
			6'd2: r = 34'sd263043837;
			6'd3: r = 34'sd133525159;
			6'd4: r = 34'sd67021687;
			6'd5: r = 34'sd33543516;
			6'd6: r = 34'sd16775851;
			6'd7: r = 34'sd8388437;
			6'd8: r = 34'sd4194283;
			6'd9: r = 34'sd2097149;
			default: begin
				if (i <= 6'd30) r = 34'sd1 <<< (6'd30 - i);
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/arc_to_cubic_bezier_top.sv -----
// ----------------------------------------------------------------------------
// arc_to_cubic_bezier_top: circular arc to path commands
// Each input transaction on the s_axis side is one arc (center, radius, start
// and end angle in Q5.26, direction flags in tuser). It produces one move-to
// or line-to toward the arc start point, then up to four cubic-to commands of
// at most a quarter turn each, on the m_axis side; tlast marks the final one.
// Work is sequential, one arc at a time, with one shared cordic unit
// (CORDIC_ITERATIONS steps, plus 6 for angle reduction), one divider and one
// multiplier that builds each point coordinate.
// s_axis_tready is high only while no arc is in progress; the last command of
// an arc sits in the output register while the next arc is taken in.
// A stalled receiver holds the output register and the sequencer waits on it.
// After reset the path counts as empty, so the first arc opens with a move-to.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_to_cubic_bezier_top import acb_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x, center_y, radius, start_angle, end_angle, zero pad
	input  wire  [159:0] s_axis_tdata,
	// anticlockwise, begin_path
	input  wire  [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// point1_x, point1_y, point2_x, point2_y, point3_x, point3_y
	output logic [191:0] m_axis_tdata,
	// segment_kind
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	acb_cmd_t           cmd;
	acb_stat_t          stat;
	seg_kind_t          kind;
	logic signed [31:0] p1x, p1y, p2x, p2y, p3x, p3y;

	acb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	acb_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.center_x      (s_axis_tdata[31:0]),
		.center_y      (s_axis_tdata[63:32]),
		.radius        (s_axis_tdata[94:64]),
		.start_angle   (s_axis_tdata[126:95]),
		.end_angle     (s_axis_tdata[158:127]),
		.anticlockwise (s_axis_tuser[0]),
		.begin_path    (s_axis_tuser[1]),
		.segment_kind  (kind),
		.point1_x      (p1x),
		.point1_y      (p1y),
		.point2_x      (p2x),
		.point2_y      (p2y),
		.point3_x      (p3x),
		.point3_y      (p3y),
		.last_segment  (m_axis_tlast)
	);

	assign m_axis_tdata = {p3y, p3x, p2y, p2x, p1y, p1x};
	assign m_axis_tuser = kind;

endmodule

`default_nettype wire

// ----- sv/acb_cordic.sv -----
// ----------------------------------------------------------------------------
// acb_cordic: iterative rotation-mode cordic
// optional quarter-turn reduction of a Q5.26 angle, one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module acb_cordic import acb_pkg::*; #(
	parameter int ITERS = CORDIC_ITERATIONS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                reduce,
	input  wire signed [34:0]  angle,
	output logic               done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	localparam int IW = $clog2(ITERS);

	typedef enum logic [1:0] {C_IDLE, C_RED, C_ROT} cstate_t;

	cstate_t            state_q;
	logic [32:0]        t_q;
	logic [2:0]         red_cnt_q;
	logic [1:0]         quad_q;
	logic [IW-1:0]      it_q;
	logic signed [33:0] x_q, y_q, z_q;

	logic [32:0]        qsh, t_nxt;
	logic               hit;
	logic signed [35:0] tsum;
	logic signed [33:0] dx, dy, at, x_n, y_n, z_n, rem_z;

	always_comb begin
		tsum  = 36'(angle) + 36'($signed({7'b0, HALF_QUARTER})) +
			36'($signed({3'b0, REDUCE_BIAS}));
		qsh   = 33'(QUARTER_TURN) << red_cnt_q;
		hit   = t_q >= qsh;
		t_nxt = hit ? t_q - qsh : t_q;
		rem_z = ($signed({7'b0, t_nxt[26:0]}) - $signed({5'b0, HALF_QUARTER})) <<< 4;
		dx    = y_q >>> it_q;
		dy    = x_q >>> it_q;
		at    = atan_step(6'(it_q));
		if (!z_q[33]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q  <= CORDIC_GAIN;
						y_q  <= '0;
						it_q <= '0;
						if (reduce) begin
							t_q       <= tsum[32:0];
							red_cnt_q <= 3'd5;
							quad_q    <= '0;
							state_q   <= C_RED;
						end else begin
							z_q     <= angle[33:0];
							quad_q  <= '0;
							state_q <= C_ROT;
						end
					end
				end
				C_RED: begin
					t_q <= t_nxt;
					if (hit && red_cnt_q < 3'd2) quad_q[red_cnt_q[0]] <= 1'b1;
					red_cnt_q <= red_cnt_q - 3'd1;
					if (red_cnt_q == 3'd0) begin
						z_q     <= rem_z;
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					x_q  <= x_n;
					y_q  <= y_n;
					z_q  <= z_n;
					it_q <= it_q + IW'(1);
					if (it_q == IW'(ITERS - 1)) begin
						done    <= 1'b1;
						state_q <= C_IDLE;
						case (quad_q)
							2'd0: begin
								cos_val <= x_n[31:0];
								sin_val <= y_n[31:0];
							end
							2'd1: begin
								cos_val <= 32'(-y_n);
								sin_val <= x_n[31:0];
							end
							2'd2: begin
								cos_val <= 32'(-x_n);
								sin_val <= 32'(-y_n);
							end
							default: begin
								cos_val <= y_n[31:0];
								sin_val <= 32'(-x_n);
							end
						endcase
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/acb_div.sv -----
// ----------------------------------------------------------------------------
// acb_div: restoring divider for the control arm length
// 64-bit dividend over 32-bit divisor, 34 quotient bits, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module acb_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] num,
	input  wire  [31:0] den,
	output logic        done,
	output logic [33:0] quot
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, den_q;
	logic [33:0] quot_q;
	logic [32:0] r2;
	logic        ge;

	assign quot = quot_q;

	always_comb begin
		r2 = {rem_q, quot_q[33]};
		ge = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
				rem_q  <= {2'b0, num[63:34]};
				quot_q <= num[33:0];
				den_q  <= den;
			end else if (busy_q) begin
				rem_q  <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
				quot_q <= {quot_q[32:0], ge};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/acb_datapath.sv -----
// ----------------------------------------------------------------------------
// acb_datapath: sweep normalization, trig, control arm and point arithmetic
// one shared multiplier feeding an accumulator, plus cordic and divider units
// ----------------------------------------------------------------------------
`default_nettype none

module acb_datapath import acb_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  acb_cmd_t           cmd,
	output acb_stat_t          stat,
	input  wire signed [31:0]  center_x,
	input  wire signed [31:0]  center_y,
	input  wire        [30:0]  radius,
	input  wire signed [31:0]  start_angle,
	input  wire signed [31:0]  end_angle,
	input  wire                anticlockwise,
	input  wire                begin_path,
	output seg_kind_t          segment_kind,
	output logic signed [31:0] point1_x,
	output logic signed [31:0] point1_y,
	output logic signed [31:0] point2_x,
	output logic signed [31:0] point2_y,
	output logic signed [31:0] point3_x,
	output logic signed [31:0] point3_y,
	output logic               last_segment
);

	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        rad_q;
	logic               acw_q, fresh_q, started_q;
	logic signed [32:0] x_q;
	logic [32:0]        m_q;
	logic [28:0]        sweep_q;
	logic signed [34:0] cs_q;
	logic signed [31:0] cs_c_q, cs_s_q, ce_c_q, ce_s_q;
	logic signed [31:0] kappa_q;
	logic               tneg_q;
	logic signed [63:0] prod_s1, acc_q;
	logic signed [31:0] pt_q [6];

	logic [28:0]        step;
	logic signed [34:0] ce, cang;
	logic signed [32:0] diff;
	logic [28:0]        sweep_nxt;
	logic               cdone, ddone;
	logic signed [31:0] cos_o, sin_o;
	logic [33:0]        dquot;
	logic signed [31:0] mul_a, mul_b, base;
	logic               neg2;
	logic [30:0]        tc;
	logic [31:0]        den;
	logic [63:0]        num;
	logic signed [63:0] rnd;
	logic signed [34:0] csum;
	logic signed [31:0] coord;

	always_comb begin
		diff = anticlockwise ? 33'(start_angle) - 33'(end_angle)
			: 33'(end_angle) - 33'(start_angle);
		if (x_q[32])
			sweep_nxt = (m_q == '0) ? '0 : FULL_TURN - m_q[28:0];
		else if (x_q > $signed({4'b0, FULL_TURN}))
			sweep_nxt = FULL_TURN;
		else
			sweep_nxt = x_q[28:0];
		step = (sweep_q > QUARTER_TURN) ? QUARTER_TURN : sweep_q;
		ce   = acw_q ? cs_q - 35'($signed({1'b0, step}))
			: cs_q + 35'($signed({1'b0, step}));
		case (cmd.cordic_src)
			SRC_START: cang = cs_q;
			SRC_END:   cang = ce;
			default:   cang = acw_q ? -35'($signed({1'b0, step, 2'b00}))
				: 35'($signed({1'b0, step, 2'b00}));
		endcase
	end

	acb_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.cordic_start),
		.reduce  (cmd.cordic_src != SRC_TAN),
		.angle   (cang),
		.done    (cdone),
		.cos_val (cos_o),
		.sin_val (sin_o)
	);

	// den = 3 * max(cos, 1), num = 4 * |sin| * radius rounded by den / 2
	always_comb begin
		tc  = (cos_o < 32'sd1) ? 31'd1 : cos_o[30:0];
		den = {tc, 1'b0} + {1'b0, tc};
		num = {prod_s1[61:0], 2'b00} + {33'b0, den[31:1]};
	end

	acb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (ddone),
		.quot   (dquot)
	);

	// operand selection per point coordinate and accumulate phase
	always_comb begin
		mul_a = '0;
		mul_b = $signed({1'b0, rad_q});
		neg2  = 1'b0;
		base  = cmd.pt_idx[0] ? cy_q : cx_q;
		if (cmd.mul_num) begin
			mul_a = sin_o[31] ? -sin_o : sin_o;
		end else if (cmd.pt_phase == 2'd0) begin
			case (cmd.pt_idx)
				3'd0: mul_a = cs_c_q;
				3'd1: mul_a = cs_s_q;
				3'd2, 3'd4: mul_a = ce_c_q;
				default: mul_a = ce_s_q;
			endcase
		end else begin
			mul_b = kappa_q;
			case (cmd.pt_idx)
				3'd0: begin
					mul_a = cs_s_q;
					neg2  = 1'b1;
				end
				3'd1: mul_a = cs_c_q;
				3'd2: mul_a = ce_s_q;
				3'd3: begin
					mul_a = ce_c_q;
					neg2  = 1'b1;
				end
				default: mul_b = '0;
			endcase
		end
		rnd  = acc_q + 64'sd536870912;
		csum = 35'(base) + 35'($signed(rnd[63:30]));
		if (csum > 35'sd2147483647) coord = 32'sh7fffffff;
		else if (csum < -35'sd2147483648) coord = 32'sh80000000;
		else coord = csum[31:0];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (cmd.pt_step && cmd.pt_phase == 2'd1) acc_q <= prod_s1;
		if (cmd.pt_step && cmd.pt_phase == 2'd2)
			acc_q <= neg2 ? acc_q - prod_s1 : acc_q + prod_s1;
		if (cmd.pt_step && cmd.pt_phase == 2'd3) pt_q[cmd.pt_idx] <= coord;
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			rad_q   <= radius;
			acw_q   <= anticlockwise;
			x_q     <= diff;
			m_q     <= diff[32] ? 33'(-diff) : '0;
			cs_q    <= 35'(start_angle);
			kappa_q <= '0;
		end
		if (cmd.mod_step) m_q <= m_q - {4'b0, FULL_TURN};
		if (cmd.sweep_set) sweep_q <= sweep_nxt;
		if (cmd.cap_s) begin
			cs_c_q <= cos_o;
			cs_s_q <= sin_o;
		end
		if (cmd.cap_e) begin
			ce_c_q <= cos_o;
			ce_s_q <= sin_o;
		end
		if (cmd.div_start) tneg_q <= sin_o[31];
		if (ddone) kappa_q <= tneg_q ? -$signed(dquot[31:0]) : $signed(dquot[31:0]);
		if (cmd.emit_move) begin
			segment_kind <= fresh_q ? KIND_MOVE : KIND_LINE;
			point1_x     <= pt_q[0];
			point1_y     <= pt_q[1];
			point2_x     <= '0;
			point2_y     <= '0;
			point3_x     <= '0;
			point3_y     <= '0;
			last_segment <= sweep_q == '0;
		end
		if (cmd.emit_cubic) begin
			segment_kind <= KIND_CUBIC;
			point1_x     <= pt_q[0];
			point1_y     <= pt_q[1];
			point2_x     <= pt_q[2];
			point2_y     <= pt_q[3];
			point3_x     <= pt_q[4];
			point3_y     <= pt_q[5];
			last_segment <= sweep_q <= QUARTER_TURN;
			sweep_q      <= sweep_q - QUARTER_TURN;
			cs_q         <= ce;
			cs_c_q       <= ce_c_q;
			cs_s_q       <= ce_s_q;
		end
	end

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			fresh_q   <= 1'b1;
		end else if (cmd.load) begin
			started_q <= 1'b1;
			fresh_q   <= begin_path || !started_q;
		end
	end

	always_comb begin
		stat.mod_done    = m_q < {4'b0, FULL_TURN};
		stat.sweep_zero  = sweep_q == '0;
		stat.last_seg    = sweep_q <= QUARTER_TURN;
		stat.cordic_done = cdone;
		stat.div_done    = ddone;
	end

endmodule

`default_nettype wire

// ----- sv/acb_ctrl.sv -----
// ----------------------------------------------------------------------------
// acb_ctrl: sequencer for one arc
// steps the datapath through normalization, trig, divide and point phases
// ----------------------------------------------------------------------------
`default_nettype none

module acb_ctrl import acb_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire        out_ready,
	input  acb_stat_t  stat,
	output acb_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_SC0, S_W0, S_MPTS, S_MEMIT, S_SCE, S_WE,
		S_STAN, S_WT, S_NUM, S_DIVS, S_WD, S_SPTS, S_SEMIT
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       out_free;

	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.cordic_src = SRC_START;
		cmd.pt_idx     = cnt_q[4:2];
		cmd.pt_phase   = cnt_q[1:0];
		case (state_q)
			S_IDLE:  cmd.load = in_valid && in_ready;
			S_MOD: begin
				cmd.mod_step  = !stat.mod_done;
				cmd.sweep_set = stat.mod_done;
			end
			S_SC0:   cmd.cordic_start = 1'b1;
			S_W0:    cmd.cap_s = stat.cordic_done;
			S_MPTS, S_SPTS: cmd.pt_step = 1'b1;
			S_MEMIT: cmd.emit_move = out_free;
			S_SCE: begin
				cmd.cordic_start = 1'b1;
				cmd.cordic_src   = SRC_END;
			end
			S_WE: begin
				cmd.cordic_src = SRC_END;
				cmd.cap_e      = stat.cordic_done;
			end
			S_STAN: begin
				cmd.cordic_start = 1'b1;
				cmd.cordic_src   = SRC_TAN;
			end
			S_WT:    cmd.cordic_src = SRC_TAN;
			S_NUM: begin
				cmd.cordic_src = SRC_TAN;
				cmd.mul_num    = 1'b1;
			end
			S_DIVS: begin
				cmd.cordic_src = SRC_TAN;
				cmd.div_start  = 1'b1;
			end
			S_SEMIT: cmd.emit_cubic = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_ready  <= 1'b1;
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						in_ready <= 1'b0;
						state_q  <= S_MOD;
					end
				end
				S_MOD:  if (stat.mod_done) state_q <= S_SC0;
				S_SC0:  state_q <= S_W0;
				S_W0: begin
					cnt_q <= '0;
					if (stat.cordic_done) state_q <= S_MPTS;
				end
				S_MPTS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) state_q <= S_MEMIT;
				end
				S_MEMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						if (stat.sweep_zero) begin
							in_ready <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_SCE;
						end
					end
				end
				S_SCE:  state_q <= S_WE;
				S_WE:   if (stat.cordic_done) state_q <= S_STAN;
				S_STAN: state_q <= S_WT;
				S_WT:   if (stat.cordic_done) state_q <= S_NUM;
				S_NUM:  state_q <= S_DIVS;
				S_DIVS: state_q <= S_WD;
				S_WD: begin
					cnt_q <= '0;
					if (stat.div_done) state_q <= S_SPTS;
				end
				S_SPTS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) state_q <= S_SEMIT;
				end
				S_SEMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						if (stat.last_seg) begin
							in_ready <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_SCE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/acb_checker.sv -----
// ----------------------------------------------------------------------------
// acb_checker: port-level checks for the arc to cubic bezier block
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module acb_checker import acb_pkg::*; (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire [159:0] s_axis_tdata,
	input wire [1:0]   s_axis_tuser,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [191:0] m_axis_tdata,
	input wire [1:0]   m_axis_tuser,
	input wire         m_axis_tlast
);

	// a stalled command keeps its content
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// one arc at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an arc is in progress");

	// a pending command that is not the last one means the arc is still running
	a_busy_mid_arc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("ready while an arc still has commands");

	// move and line commands carry only one point
	a_single_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_CUBIC |-> m_axis_tdata[191:64] == '0)
		else $error("move or line with nonzero control points");

endmodule

bind arc_to_cubic_bezier_top acb_checker u_acb_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for arc_to_cubic_bezier_top
// Sends a table of directed arcs, then random arcs, over the input stream.
// A local fixed point model predicts the path commands for each arc, and every
// command taken from the output stream is checked against the oldest
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import acb_pkg::*;

	localparam int ITER = 24;
	localparam longint QT = 105414357;
	localparam longint FT = 4 * QT;
	localparam longint GAIN = 652032874;
	localparam int N_RANDOM = 395;

	typedef struct {
		logic [31:0] cx, cy;
		logic [30:0] rad;
		logic [31:0] sa, ea;
		logic        acw, bp;
		logic        typed;  // expected command typed in below
		seg_kind_t   kind;
		logic [31:0] px, py;
	} arc_t;

	typedef struct {
		seg_kind_t    kind;
		logic [191:0] pts;
		logic         last;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	cmd_t cmd_q[$];
	int n_err = 0;
	bit path_open = 0;
	bit calm = 0;

	arc_to_cubic_bezier_top #(.CORDIC_ITERATIONS(ITER)) dut (.*);

	always #5 clk = ~clk;

	// ---------------- prediction ----------------
	function automatic longint atan_of(int i);
		longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return t[i];
		if (i <= 30) return longint'(1) << (30 - i);
		return 0;
	endfunction

	task automatic rotate(input longint theta, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = GAIN; y = 0; z = theta;
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_of(i);
			end else begin
				x += dx; y -= dy; z += atan_of(i);
			end
		end
		c = x; s = y;
	endtask

	task automatic trig(input longint a, output longint c, output longint s);
		longint n, q, r, rc, rs;
		n = a + QT / 2;
		q = (n >= 0) ? n / QT : -((-n + QT - 1) / QT);
		r = a - q * QT;
		rotate(r * 16, rc, rs);
		case (q & 3)
			0: begin c = rc;  s = rs;  end
			1: begin c = -rs; s = rc;  end
			2: begin c = -rc; s = -rs; end
			default: begin c = rs; s = -rc; end
		endcase
	endtask

	function automatic logic [31:0] place(longint base, longint p, longint q);
		longint v;
		v = base + ((p + q + (longint'(1) << 29)) >>> 30);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	task automatic predict_arc(input arc_t a);
		longint cx, cy, rad, sa, ea, sweep, dir, cs, ce, c0, s0;
		longint cS, sS, cE, sE, tc, ts, kappa;
		longint unsigned num, den;
		cmd_t c;
		int n;
		cx = longint'(signed'(a.cx)); cy = longint'(signed'(a.cy));
		rad = longint'(a.rad);
		sa = longint'(signed'(a.sa)); ea = longint'(signed'(a.ea));
		trig(sa, c0, s0);
		c.kind = (a.bp || !path_open) ? KIND_MOVE : KIND_LINE;
		c.pts = {128'd0, place(cy, s0 * rad, 0), place(cx, c0 * rad, 0)};
		if (!a.acw && ea < sa) ea += ((sa - ea + FT - 1) / FT) * FT;
		else if (a.acw && sa < ea) sa += ((ea - sa + FT - 1) / FT) * FT;
		if (!a.acw && ea - sa > FT) ea = sa + FT;
		else if (a.acw && sa - ea > FT) ea = sa - FT;
		sweep = ea > sa ? ea - sa : sa - ea;
		path_open = 1;
		c.last = sweep <= 0;
		if (a.typed) begin
			c.kind = a.kind;
			c.pts = {128'd0, a.py, a.px};
		end
		cmd_q.push_back(c);
		dir = a.acw ? -1 : 1;
		cs = sa;
		n = 1;
		while (sweep > 0 && n < 5) begin
			ce = cs + dir * (sweep > QT ? QT : sweep);
			trig(cs, cS, sS);
			trig(ce, cE, sE);
			rotate((ce - cs) * 4, tc, ts);
			if (tc < 1) tc = 1;
			num = 4 * longint'(ts < 0 ? -ts : ts) * rad;
			den = 3 * tc;
			kappa = longint'((num + den / 2) / den);
			if (ts < 0) kappa = -kappa;
			c.kind = KIND_CUBIC;
			c.pts = {place(cy, sE * rad, 0), place(cx, cE * rad, 0),
				place(cy, sE * rad, -cE * kappa), place(cx, cE * rad, sE * kappa),
				place(cy, sS * rad, cS * kappa), place(cx, cS * rad, -sS * kappa)};
			sweep -= QT;
			cs = ce;
			c.last = sweep <= 0;
			cmd_q.push_back(c);
			n++;
		end
	endtask

	// ---------------- stimulus ----------------
	function automatic int pause();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_arc(input arc_t a);
		int g;
		g = pause();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tdata <= {1'b0, a.ea, a.sa, a.rad, a.cy, a.cx};
		s_axis_tuser <= {a.bp, a.acw};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_arc(a);
	endtask

	function automatic arc_t rand_arc();
		arc_t a;
		int r;
		r = $urandom_range(0, 9);
		a.typed = 0; a.kind = KIND_MOVE; a.px = 0; a.py = 0;
		a.acw = $urandom_range(0, 1);
		a.bp = ($urandom_range(0, 7) == 0);
		if (r < 2) begin
			// full range fields, saturation and huge angles
			a.cx = $urandom; a.cy = $urandom; a.rad = $urandom;
			a.sa = $urandom; a.ea = $urandom;
		end else begin
			a.cx = $urandom_range(0, 1 << 26) - (1 << 25);
			a.cy = $urandom_range(0, 1 << 26) - (1 << 25);
			a.rad = $urandom_range(0, 1 << 24);
			a.sa = $urandom_range(0, 2 * FT) - FT;
			if (r < 8)
				a.ea = a.sa + (a.acw ? -1 : 1) * int'($urandom_range(0, FT + QT));
			else
				a.ea = a.sa + int'($urandom_range(0, 8)) - 4;
		end
		return a;
	endfunction

	// ---------------- checking ----------------
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (cmd_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected command kind %0d", m_axis_tuser);
			end else begin
				if (m_axis_tuser !== cmd_q[0].kind || m_axis_tdata !== cmd_q[0].pts ||
						m_axis_tlast !== cmd_q[0].last) begin
					n_err++;
					if (n_err <= 10) begin
						$display("mismatch: kind exp %0d got %0d, last exp %0b got %0b",
							cmd_q[0].kind, m_axis_tuser, cmd_q[0].last, m_axis_tlast);
						$display("  points exp %h", cmd_q[0].pts);
						$display("  points got %h", m_axis_tdata);
					end
				end
				void'(cmd_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (calm) m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 99) < 2) m_axis_tready <= 1'b0;
		else if (!m_axis_tready && $urandom_range(0, 29) == 0) m_axis_tready <= 1'b1;
		else if (m_axis_tready && $urandom_range(0, 4) == 0) m_axis_tready <= 1'b0;
		else if (!m_axis_tready && $urandom_range(0, 2) == 0 && $urandom_range(0, 9) < 9)
			m_axis_tready <= 1'b1;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arc_t tbl[$];
		arc_t a;
		// radius zero commands are exact: the point is the center
		tbl.push_back('{32'sd5, 32'sd7, 31'd0, 0, 0, 0, 0, 1, KIND_MOVE, 32'sd5, 32'sd7});
		tbl.push_back('{-32'sd9, 32'sd3, 31'd0, 0, 0, 1, 0, 1, KIND_LINE, -32'sd9, 32'sd3});
		tbl.push_back('{32'h7fffffff, 32'h80000000, 31'd0, 32'h7fffffff, 32'h80000000,
			0, 1, 1, KIND_MOVE, 32'h7fffffff, 32'h80000000});
		// quarter turns both ways, full turn, capped sweep
		tbl.push_back('{0, 0, 31'h10000, 0, QT, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h10000, 0, -QT, 1, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{32'h100000, -32'sh200000, 31'h50000, 0, FT, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h20000, 32'sd1000, 32'sd1000 - FT, 1, 1, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h20000, -FT, 3 * FT, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h20000, 3 * FT, -FT, 1, 0, 0, KIND_MOVE, 0, 0});
		// end behind start wraps forward, whole turns back give zero sweep
		tbl.push_back('{0, 0, 31'h30000, QT, 0, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h30000, 0, -FT, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h30000, 0, 2 * FT, 1, 0, 0, KIND_MOVE, 0, 0});
		// residual sweeps of one lsb and just past a quarter
		tbl.push_back('{0, 0, 31'h40000, 0, 1, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h40000, 0, -1, 1, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h40000, 0, QT + 1, 0, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h40000, 32'sd5, 3 * QT + 7, 0, 0, 0, KIND_MOVE, 0, 0});
		// saturation at both ends, extreme angles
		tbl.push_back('{32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0, FT, 0, 0, 0,
			KIND_MOVE, 0, 0});
		tbl.push_back('{32'h80000000, 32'h80000000, 31'h7fffffff, 2 * QT, 6 * QT, 0, 1, 0,
			KIND_MOVE, 0, 0});
		tbl.push_back('{32'h12345678, 32'hedcba987, 31'h7fffffff, 32'h7fffffff,
			32'h80000000, 1, 0, 0, KIND_MOVE, 0, 0});
		tbl.push_back('{0, 0, 31'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0,
			KIND_MOVE, 0, 0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tbl[i]) send_arc(tbl[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
			a = rand_arc();
			send_arc(a);
		end
		s_axis_tvalid <= 1'b0;
		calm = 0;
		wait (cmd_q.size() == 0);
		repeat (800) @(posedge clk);
		if (n_err == 0 && cmd_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
